// ===== hdl/packed_sample_frame_builder_macros.svh =====
// Assertion macros for the packed sample frame builder checker.
// Needs nothing else; included by the checker file by bare name.
`ifndef PACKED_SAMPLE_FRAME_BUILDER_MACROS_SVH
`define PACKED_SAMPLE_FRAME_BUILDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSFB_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSFB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/psfb_pkg.sv =====
// Shared constants, types and byte-slot codes of the packed sample frame builder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package psfb_pkg;

    // Frame geometry
    localparam int CHUNK_SAMPLES = 512;
    localparam int POS_W         = $clog2(CHUNK_SAMPLES);
    localparam int META_BYTES    = 10;
    localparam logic [15:0] BODY_LEN_FIELD = 16'(META_BYTES + 3 * CHUNK_SAMPLES);
    localparam logic [15:0] CHUNK_LEN   = 16'(CHUNK_SAMPLES);
    localparam logic [31:0] CHUNK_STEP  = 32'(CHUNK_SAMPLES);

    // Port widths
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 8;
    localparam int M_TUSER_W  = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 18;
    localparam int RATE_W     = 18;

    // Converter word decoding
    localparam logic [15:0] CHAN_BIT    = 16'h4000;
    localparam logic [15:0] MARK_MASK   = 16'hC003;
    localparam logic [15:0] MARK_SECOND = 16'h4000;
    localparam logic [11:0] CODE_FLIP   = 12'h800;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_HEADER_FIRST  = 2'd0,
        REG_HEADER_SECOND = 2'd1,
        REG_FRAME_TYPE    = 2'd2,
        REG_SAMPLE_RATE   = 2'd3
    } cfg_reg_t;

    // Byte slots of one item's output
    typedef logic [4:0] byte_idx_t;
    localparam byte_idx_t IDX_SYNC_A     = 5'd0;
    localparam byte_idx_t IDX_SYNC_B     = 5'd1;
    localparam byte_idx_t IDX_TYPE       = 5'd2;
    localparam byte_idx_t IDX_LEN_HI     = 5'd3;
    localparam byte_idx_t IDX_LEN_LO     = 5'd4;
    localparam byte_idx_t IDX_SEQ_B3     = 5'd5;
    localparam byte_idx_t IDX_SEQ_B2     = 5'd6;
    localparam byte_idx_t IDX_SEQ_B1     = 5'd7;
    localparam byte_idx_t IDX_SEQ_B0     = 5'd8;
    localparam byte_idx_t IDX_RATE_B3    = 5'd9;
    localparam byte_idx_t IDX_RATE_B2    = 5'd10;
    localparam byte_idx_t IDX_RATE_B1    = 5'd11;
    localparam byte_idx_t IDX_RATE_B0    = 5'd12;
    localparam byte_idx_t IDX_COUNT_HI   = 5'd13;
    localparam byte_idx_t IDX_COUNT_LO   = 5'd14;
    localparam byte_idx_t IDX_SAMPLE_HI  = 5'd15;
    localparam byte_idx_t IDX_SAMPLE_MID = 5'd16;
    localparam byte_idx_t IDX_SAMPLE_LO  = 5'd17;
    localparam byte_idx_t IDX_CHECKSUM   = 5'd18;

    // Decoded sample handed from the unpacker to the framer
    typedef struct packed {
        logic [23:0] code_pair;   // second channel code in [23:12], first in [11:0]
        logic        invalid;
    } sample_t;

endpackage

// ===== hdl/psfb_unpack.sv =====
// Converter word pair decoder: channel swap, marker check and offset-binary to
// two's-complement conversion. Depends on psfb_pkg.
`timescale 1ns / 1ps

module psfb_unpack
    import psfb_pkg::*;
(
    input  logic [15:0] word_first,
    input  logic [15:0] word_second,
    output sample_t     sample
);

    logic        swap;
    logic [15:0] chan_a;
    logic [15:0] chan_b;

    // Put the word with the channel bit clear first
    assign swap   = ((word_first & CHAN_BIT) != '0) && ((word_second & CHAN_BIT) == '0);
    assign chan_a = swap ? word_second : word_first;
    assign chan_b = swap ? word_first  : word_second;

    // Check markers and flip the sign bit of each 12-bit code
    always_comb begin
        sample.invalid   = ((chan_a & MARK_MASK) != '0) || ((chan_b & MARK_MASK) != MARK_SECOND);
        sample.code_pair = {chan_b[13:2] ^ CODE_FLIP, chan_a[13:2] ^ CODE_FLIP};
    end

endmodule

// ===== hdl/packed_sample_frame_builder.sv =====
// Packed sample frame builder: turns converter word pairs into a framed byte stream.
// One sample transaction in yields 3 output bytes for an ordinary sample, 18 for the
// first sample of a chunk (15 header bytes ahead of it) and 4 for the last (checksum
// byte after it). The byte-wide output register moves one byte per cycle when not
// stalled by m_tready. An input register lets the next sample transaction be taken
// while the current one is serialized; samples pass input, work and output registers.
// Configuration writes are only to be made while the block is idle.
// Depends on psfb_pkg and psfb_unpack.
`timescale 1ns / 1ps

module packed_sample_frame_builder
    import psfb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: word_first [15:0], word_second [31:16], sequence_low [47:32]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // m_tdata: data_byte [7:0]; m_tlast: frame_end
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,
    // m_tuser: item_last [0], sample_invalid [1]
    output logic [M_TUSER_W-1:0]  m_tuser,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration
    logic [7:0]        header_first_reg;
    logic [7:0]        header_second_reg;
    logic [7:0]        frame_type_reg;
    logic [RATE_W-1:0] sample_rate_reg;

    // Input register
    logic                 in_valid_reg, in_valid_next;
    logic [S_TDATA_W-1:0] in_data_reg;

    // Work register: the item being serialized
    logic        work_valid_reg, work_valid_next;
    logic [23:0] work_pair_reg;
    logic        work_invalid_reg;
    logic        work_end_reg;
    logic [31:0] work_seq_reg;
    byte_idx_t   work_idx_reg, work_idx_next;

    // Frame state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       check_reg, check_next;
    logic [31:0]      expected_reg, expected_next;
    logic             seq_known_reg, seq_known_next;
    logic [31:0]      invalid_count_reg, invalid_count_next;

    // Output register
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_last_reg;
    logic [M_TUSER_W-1:0] m_user_reg;

    logic        s_accept;
    logic        out_ready;
    logic        emit;
    logic        last_byte;
    logic        work_done;
    logic        load_work;
    logic        is_start;
    logic        is_end;
    logic [15:0] seq_low;
    logic [15:0] seq_delta;
    logic [31:0] first_seq;
    logic [7:0]  cur_byte;
    logic        cur_checked;
    logic [7:0]  check_base;
    sample_t     sample;

    psfb_unpack u_unpack (
        .word_first  (in_data_reg[15:0]),
        .word_second (in_data_reg[31:16]),
        .sample      (sample)
    );

    // Handshake and flow control
    assign out_ready = !m_valid_reg || m_tready;
    assign emit      = work_valid_reg && out_ready;
    assign last_byte = work_end_reg ? (work_idx_reg == IDX_CHECKSUM)
                                    : (work_idx_reg == IDX_SAMPLE_LO);
    assign work_done = emit && last_byte;
    assign load_work = in_valid_reg && (!work_valid_reg || work_done);
    assign s_tready  = !in_valid_reg || load_work;
    assign s_accept  = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    // Chunk position and sequence rebuild for the item moving to the work register
    assign is_start  = (pos_reg == '0);
    assign is_end    = (pos_reg == POS_W'(CHUNK_SAMPLES - 1));
    assign seq_low   = in_data_reg[47:32];
    assign seq_delta = seq_low - expected_reg[15:0];
    assign first_seq = seq_known_reg ? (expected_reg + {{16{seq_delta[15]}}, seq_delta})
                                     : {16'd0, seq_low};

    always_comb begin
        in_valid_next      = in_valid_reg;
        pos_next           = pos_reg;
        expected_next      = expected_reg;
        seq_known_next     = seq_known_reg;
        invalid_count_next = invalid_count_reg;
        work_valid_next    = work_valid_reg;

        if (load_work) begin
            in_valid_next = 1'b0;
        end
        if (s_accept) begin
            in_valid_next = 1'b1;
        end

        if (work_done) begin
            work_valid_next = 1'b0;
        end
        if (load_work) begin
            work_valid_next = 1'b1;
            pos_next        = is_end ? '0 : pos_reg + 1'b1;
            if (is_start) begin
                expected_next  = first_seq + CHUNK_STEP;
                seq_known_next = 1'b1;
            end
            if (sample.invalid && (invalid_count_reg != '1)) begin
                invalid_count_next = invalid_count_reg + 32'd1;
            end
        end
    end

    // Select the byte for the current slot
    always_comb begin
        case (work_idx_reg)
            IDX_SYNC_A:     cur_byte = header_first_reg;
            IDX_SYNC_B:     cur_byte = header_second_reg;
            IDX_TYPE:       cur_byte = frame_type_reg;
            IDX_LEN_HI:     cur_byte = BODY_LEN_FIELD[15:8];
            IDX_LEN_LO:     cur_byte = BODY_LEN_FIELD[7:0];
            IDX_SEQ_B3:     cur_byte = work_seq_reg[31:24];
            IDX_SEQ_B2:     cur_byte = work_seq_reg[23:16];
            IDX_SEQ_B1:     cur_byte = work_seq_reg[15:8];
            IDX_SEQ_B0:     cur_byte = work_seq_reg[7:0];
            IDX_RATE_B3:    cur_byte = 8'd0;
            IDX_RATE_B2:    cur_byte = {6'd0, sample_rate_reg[17:16]};
            IDX_RATE_B1:    cur_byte = sample_rate_reg[15:8];
            IDX_RATE_B0:    cur_byte = sample_rate_reg[7:0];
            IDX_COUNT_HI:   cur_byte = CHUNK_LEN[15:8];
            IDX_COUNT_LO:   cur_byte = CHUNK_LEN[7:0];
            IDX_SAMPLE_HI:  cur_byte = work_pair_reg[23:16];
            IDX_SAMPLE_MID: cur_byte = work_pair_reg[15:8];
            IDX_SAMPLE_LO:  cur_byte = work_pair_reg[7:0];
            IDX_CHECKSUM:   cur_byte = check_reg;
            default:        cur_byte = 8'd0;
        endcase
    end

    // Checksum covers everything from the sequence field through the sample bytes
    assign cur_checked = (work_idx_reg >= IDX_SEQ_B3) && (work_idx_reg <= IDX_SAMPLE_LO);
    assign check_base  = (work_idx_reg == IDX_SYNC_A) ? 8'd0 : check_reg;

    always_comb begin
        check_next    = check_reg;
        work_idx_next = work_idx_reg;
        if (emit) begin
            check_next    = cur_checked ? (check_base ^ cur_byte) : check_base;
            work_idx_next = work_idx_reg + 5'd1;
        end
        if (load_work) begin
            work_idx_next = is_start ? IDX_SYNC_A : IDX_SAMPLE_HI;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_first_reg  <= '0;
            header_second_reg <= '0;
            frame_type_reg    <= '0;
            sample_rate_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_HEADER_FIRST:  header_first_reg  <= cfg_wdata[7:0];
                REG_HEADER_SECOND: header_second_reg <= cfg_wdata[7:0];
                REG_FRAME_TYPE:    frame_type_reg    <= cfg_wdata[7:0];
                REG_SAMPLE_RATE:   sample_rate_reg   <= cfg_wdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Control and frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            work_valid_reg    <= 1'b0;
            work_idx_reg      <= IDX_SYNC_A;
            pos_reg           <= '0;
            check_reg         <= '0;
            expected_reg      <= '0;
            seq_known_reg     <= 1'b0;
            invalid_count_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            in_valid_reg      <= in_valid_next;
            work_valid_reg    <= work_valid_next;
            work_idx_reg      <= work_idx_next;
            pos_reg           <= pos_next;
            check_reg         <= check_next;
            expected_reg      <= expected_next;
            seq_known_reg     <= seq_known_next;
            invalid_count_reg <= invalid_count_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_tdata;
        end
        if (load_work) begin
            work_pair_reg    <= sample.code_pair;
            work_invalid_reg <= sample.invalid;
            work_end_reg     <= is_end;
            work_seq_reg     <= first_seq;
        end
        if (emit) begin
            m_data_reg <= cur_byte;
            m_last_reg <= (work_idx_reg == IDX_CHECKSUM);
            m_user_reg <= {work_invalid_reg, last_byte};
        end
    end

endmodule

// ===== hdl/psfb_checker.sv =====
// Port-level checker for the packed sample frame builder, bound to the top level.
// Depends on psfb_pkg and packed_sample_frame_builder_macros.svh.
`timescale 1ns / 1ps
`include "packed_sample_frame_builder_macros.svh"

module psfb_checker
    import psfb_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // Hold a stalled byte
    `PSFB_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled output changed")

    // Checksum byte always closes its item
    `PSFB_ASSERT_IMPL(a_cksum_last, aclk, aresetn, m_tvalid && m_tlast, m_tuser[0], "checksum byte not last of item")

    // Bytes of one item follow without gaps and share the invalid flag
    `PSFB_ASSERT_NEXT(a_item_burst, aclk, aresetn, m_tvalid && m_tready && !m_tuser[0], m_tvalid && (m_tuser[1] == $past(m_tuser[1])), "item bytes broken up")

endmodule

bind packed_sample_frame_builder psfb_checker u_psfb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/psfb_frame_checker.sv =====
// Frame stream checker for the packed sample frame builder: watches both streams and the
// register port, predicts the bytes of every accepted sample and compares them in order.
// Depends on psfb_pkg for port widths, the chunk size and register indexes.
`timescale 1ns / 1ps

module psfb_frame_checker
    import psfb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tlast,
    input  logic [M_TUSER_W-1:0]  m_tuser,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatch_count,
    output int                    pending_count
);

    // Word decoding and header constants, kept apart from the block's own
    localparam logic [15:0] SWAP_BIT     = 16'h4000;
    localparam logic [15:0] MARKER_MASK  = 16'hC003;
    localparam logic [15:0] MARKER_B     = 16'h4000;
    localparam logic [11:0] OFFSET_FLIP  = 12'h800;
    localparam int          HDR_META     = 10;
    localparam int          PRINT_CAP    = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       frame_end;
        logic       item_last;
        logic       invalid;
    } frame_byte_t;

    frame_byte_t expected_bytes[$];
    frame_byte_t head;

    // Register copies
    logic [7:0]        sync_first;
    logic [7:0]        sync_second;
    logic [7:0]        type_byte;
    logic [RATE_W-1:0] rate_hz;

    // Framing state
    int unsigned chunk_pos;
    logic [7:0]  frame_xor;
    logic [31:0] seq_next;
    logic        seq_known;
    logic [31:0] bad_total;

    int mismatch_total;
    int pending;
    int byte_index;

    assign mismatch_count = mismatch_total;
    assign pending_count  = pending;

    task automatic report_mismatch(input string msg);
        if (mismatch_total < PRINT_CAP) begin
            $display("[%0t] byte %0d: %s", $time, byte_index, msg);
        end
        mismatch_total++;
    endtask

    task automatic push_byte(input logic [7:0] d, input logic fend, input logic ilast,
                             input logic checked, input logic bad);
        frame_byte_t fb;
        fb.data      = d;
        fb.frame_end = fend;
        fb.item_last = ilast;
        fb.invalid   = bad;
        expected_bytes.push_back(fb);
        if (checked) begin
            frame_xor = frame_xor ^ d;
        end
    endtask

    // Push a value most significant byte first
    task automatic push_be(input logic [31:0] value, input int nbytes, input logic checked,
                           input logic bad);
        int k;
        for (k = nbytes - 1; k >= 0; k--) begin
            push_byte(value[8*k +: 8], 1'b0, 1'b0, checked, bad);
        end
    endtask

    // Work out every byte that one sample transaction causes
    task automatic predict_sample(input logic [S_TDATA_W-1:0] beat);
        logic [15:0] wa;
        logic [15:0] wb;
        logic [15:0] wlow;
        logic [15:0] tmp;
        logic [15:0] diff;
        logic [11:0] code_a;
        logic [11:0] code_b;
        logic [23:0] pair;
        logic [31:0] first_seq;
        logic        bad;
        logic        closing;
        wa   = beat[15:0];
        wb   = beat[31:16];
        wlow = beat[47:32];

        // swap a pair whose channel bits are reversed
        if ((wa & SWAP_BIT) != 16'h0 && (wb & SWAP_BIT) == 16'h0) begin
            tmp = wa;
            wa  = wb;
            wb  = tmp;
        end
        bad = ((wa & MARKER_MASK) != 16'h0) || ((wb & MARKER_MASK) != MARKER_B);
        if (bad && bad_total != 32'hFFFF_FFFF) begin
            bad_total++;
        end
        code_b  = wb[13:2] ^ OFFSET_FLIP;
        code_a  = wa[13:2] ^ OFFSET_FLIP;
        pair    = {code_b, code_a};
        closing = (chunk_pos + 1 >= CHUNK_SAMPLES);

        // header ahead of the first sample of a chunk
        if (chunk_pos == 0) begin
            if (seq_known) begin
                diff      = wlow - seq_next[15:0];
                first_seq = seq_next + {{16{diff[15]}}, diff};
            end else begin
                first_seq = {16'h0, wlow};
                seq_known = 1'b1;
            end
            seq_next  = first_seq + 32'(CHUNK_SAMPLES);
            frame_xor = 8'h00;
            push_byte(sync_first, 1'b0, 1'b0, 1'b0, bad);
            push_byte(sync_second, 1'b0, 1'b0, 1'b0, bad);
            push_byte(type_byte, 1'b0, 1'b0, 1'b0, bad);
            push_be(32'(16'(HDR_META + 3 * CHUNK_SAMPLES)), 2, 1'b0, bad);
            push_be(first_seq, 4, 1'b1, bad);
            push_be(32'(rate_hz), 4, 1'b1, bad);
            push_be(32'(16'(CHUNK_SAMPLES)), 2, 1'b1, bad);
        end

        push_byte(pair[23:16], 1'b0, 1'b0, 1'b1, bad);
        push_byte(pair[15:8], 1'b0, 1'b0, 1'b1, bad);
        push_byte(pair[7:0], 1'b0, !closing, 1'b1, bad);

        // checksum after the last sample of a chunk
        if (closing) begin
            push_byte(frame_xor, 1'b1, 1'b1, 1'b0, bad);
            chunk_pos = 0;
        end else begin
            chunk_pos++;
        end
    endtask

    // Compare results, track register writes, predict accepted samples
    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_bytes.delete();
            sync_first  = 8'h00;
            sync_second = 8'h00;
            type_byte   = 8'h00;
            rate_hz     = '0;
            chunk_pos   = 0;
            frame_xor   = 8'h00;
            seq_next    = 32'h0;
            seq_known   = 1'b0;
            bad_total   = 32'h0;
            byte_index  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h", m_tdata));
                end else begin
                    head = expected_bytes.pop_front();
                    if (m_tdata !== head.data)
                        report_mismatch($sformatf("data %02h, expected %02h",
                                                  m_tdata, head.data));
                    if (m_tlast !== head.frame_end)
                        report_mismatch($sformatf("frame end %b, expected %b",
                                                  m_tlast, head.frame_end));
                    if (m_tuser[0] !== head.item_last)
                        report_mismatch($sformatf("item last %b, expected %b",
                                                  m_tuser[0], head.item_last));
                    if (m_tuser[1] !== head.invalid)
                        report_mismatch($sformatf("invalid flag %b, expected %b",
                                                  m_tuser[1], head.invalid));
                end
                byte_index++;
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_HEADER_FIRST:  sync_first  = cfg_wdata[7:0];
                    REG_HEADER_SECOND: sync_second = cfg_wdata[7:0];
                    REG_FRAME_TYPE:    type_byte   = cfg_wdata[7:0];
                    REG_SAMPLE_RATE:   rate_hz     = cfg_wdata[RATE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_sample(s_tdata);
            end
        end
        pending = expected_bytes.size();
    end

endmodule

// ===== tb/sv/packed_sample_frame_builder_tb.sv =====
// Top of the packed sample frame builder testbench: clock, reset, register setup and
// sample stimulus under several idle and stall settings, plus the final verdict.
// Depends on psfb_pkg, the block itself and psfb_frame_checker.
`timescale 1ns / 1ps

module packed_sample_frame_builder_tb;
    import psfb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 32;
    localparam int PHASE_ITEMS  = 64;
    localparam int DIRECTED_N   = 15;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int          mismatch_count;
    int          pending_count;
    int          idle_pct;
    int          stall_pct;
    int          cycle_count = 0;
    int          samples_sent;
    int          frames_closed = 0;
    logic [31:0] seq_run;

    packed_sample_frame_builder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    psfb_frame_checker frame_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stall the receiver at the current rate
    always @(negedge aclk) begin
        m_tready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);
    end

    // Count cycles and closed frames; end a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (m_tvalid && m_tready && m_tlast) begin
            frames_closed <= frames_closed + 1;
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d bytes outstanding", cycle_count,
                     pending_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Write all four registers, then release the port
    task automatic load_registers(input logic [17:0] first_v, input logic [17:0] second_v,
                                  input logic [17:0] type_v, input logic [17:0] rate_v);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_HEADER_FIRST;
        cfg_wdata <= first_v;
        @(negedge aclk);
        cfg_addr  <= REG_HEADER_SECOND;
        cfg_wdata <= second_v;
        @(negedge aclk);
        cfg_addr  <= REG_FRAME_TYPE;
        cfg_wdata <= type_v;
        @(negedge aclk);
        cfg_addr  <= REG_SAMPLE_RATE;
        cfg_wdata <= rate_v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one sample transaction; called and returning at a falling edge
    task automatic send_sample(input logic [S_TDATA_W-1:0] beat);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
        @(negedge aclk);
    endtask

    // Hold until every predicted byte has come out
    task automatic wait_drained();
        while (pending_count != 0) @(negedge aclk);
    endtask

    // One well-formed channel word with a random code
    function automatic logic [15:0] channel_word(input logic chan_b);
        logic [11:0] code;
        code = 12'($urandom);
        return {1'b0, chan_b, code, 2'b00};
    endfunction

    // Mostly well-formed pairs, some swapped, some with a broken marker, some noise
    function automatic logic [S_TDATA_W-1:0] make_sample(input logic [15:0] seq_low);
        logic [15:0] wa;
        logic [15:0] wb;
        logic [15:0] tmp;
        int          pick;
        int          bitpos;
        pick = $urandom_range(99);
        wa   = channel_word(1'b0);
        wb   = channel_word(1'b1);
        if (pick >= 55 && pick < 70) begin
            tmp = wa;
            wa  = wb;
            wb  = tmp;
        end else if (pick >= 70 && pick < 85) begin
            case ($urandom_range(3))
                0: bitpos = 0;
                1: bitpos = 1;
                2: bitpos = 14;
                default: bitpos = 15;
            endcase
            if ($urandom_range(1) == 1) wa[bitpos] = ~wa[bitpos];
            else wb[bitpos] = ~wb[bitpos];
        end else if (pick >= 85) begin
            wa = 16'($urandom);
            wb = 16'($urandom);
        end
        return {seq_low, wb, wa};
    endfunction

    // Directed pairs: extremes, swaps, each marker bit wrong, both channel bits set
    function automatic logic [31:0] directed_pair(input int idx);
        case (idx)
            0:  return {16'h0000, 16'h0000};
            1:  return {16'hFFFF, 16'hFFFF};
            2:  return {16'h4000, 16'h0000};
            3:  return {16'h7FFC, 16'h3FFC};
            4:  return {16'h3FFC, 16'h7FFC};
            5:  return {16'h0000, 16'h4000};
            6:  return {16'h4000, 16'h0001};
            7:  return {16'h4000, 16'h0002};
            8:  return {16'h4000, 16'h8000};
            9:  return {16'h4001, 16'h0000};
            10: return {16'h4002, 16'h0000};
            11: return {16'hC000, 16'h0000};
            12: return {16'h4000, 16'h4000};
            13: return {16'h5554, 16'h2AA8};
            default: return {16'h6AA8, 16'h1554};
        endcase
    endfunction

    // Random samples with a running sequence that jumps now and then
    task automatic run_phase(input int items, input int idle, input int stall);
        logic [15:0] seq_low;
        int          i;
        idle_pct  = idle;
        stall_pct = stall;
        for (i = 0; i < items; i++) begin
            if ($urandom_range(99) < 3) begin
                case ($urandom_range(3))
                    0: seq_run = seq_run + 32'h0000_7FFF;
                    1: seq_run = seq_run + 32'hFFFF_8000;
                    2: seq_run = seq_run + {{16{1'b1}}, 16'($urandom_range(65535, 65000))};
                    default: seq_run = seq_run + 32'($urandom);
                endcase
            end
            seq_low = ($urandom_range(99) < 10) ? 16'($urandom) : seq_run[15:0];
            send_sample(make_sample(seq_low));
            seq_run++;
        end
        s_tvalid <= 1'b0;
        wait_drained();
    endtask

    initial begin
        int i;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = REG_HEADER_FIRST;
        cfg_wdata     = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        samples_sent  = 0;
        seq_run       = 32'h0000_FFF0;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part; upper data bits on the byte registers must be dropped
        load_registers(18'h3FFFF, 18'h3FF00, 18'h2A5FF, 18'd200000);
        for (i = 0; i < DIRECTED_N; i++) begin
            send_sample({(i == 0) ? seq_run[15:0] : 16'($urandom), directed_pair(i)});
            seq_run++;
        end
        s_tvalid <= 1'b0;
        wait_drained();

        // Random phases, each under its own register setting
        load_registers(18'h000A5, 18'h0005A, 18'($urandom), 18'($urandom_range(200000)));
        run_phase(PHASE_ITEMS, 0, 0);
        load_registers(18'h0, 18'h0, 18'h0, 18'h0);
        run_phase(PHASE_ITEMS, 70, 0);
        load_registers(18'($urandom), 18'($urandom), 18'($urandom), 18'h3FFFF);
        run_phase(PHASE_ITEMS, 0, 70);
        load_registers(18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom));
        run_phase(PHASE_ITEMS, 6, 6);

        // Let any stray byte show up before the verdict
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Ran %0d samples in %0d cycles, %0d frames closed by a checksum byte.",
                 samples_sent, cycle_count, frames_closed);
        $display("Covered marker, swap and extreme pairs, sequence jumps and four pacing modes.");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/psfb_pkg.sv
hdl/psfb_unpack.sv
hdl/packed_sample_frame_builder.sv
hdl/psfb_checker.sv
tb/sv/psfb_frame_checker.sv
tb/sv/packed_sample_frame_builder_tb.sv
